>>> rtl/mpsb_pkg.sv
`default_nettype none
package mpsb_pkg;

  typedef enum logic [1:0] {
    REQ_HEADER = 2'd0,
    REQ_DATA   = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_kind_t;

  localparam logic [1:0] MODE_SET   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         sprite_w;
    logic [7:0]         sprite_h;
    logic [1:0]         draw_mode;
    logic [7:0]         data_byte;
    logic [2:0]         read_page;
    logic [6:0]         read_column;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       sprite_done;
    logic       stray_byte;
  } rsp_t;

  typedef enum logic [5:0] {
    S_SWEEP = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD0   = 6'b000100,
    S_MRG0  = 6'b001000,
    S_MRG1  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

endpackage
`default_nettype wire

>>> rtl/mpsb_ram.sv
`default_nettype none
module mpsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/mono_page_sprite_blitter_core.sv
// Monochrome page framebuffer with a sprite blitter.
// Requests arrive on the in_ channel (valid/ready), one word per request:
// a sprite header, a sprite column byte, a framebuffer read or a clear-all.
// Every request returns exactly one word on the out_ channel, in order.
// The framebuffer sits in one simple dual-port RAM with a registered read;
// each on-screen column byte is read, merged and rewritten in one or two pages.
// A header or stray byte goes straight to the response step; a read and a
// column byte that touches the screen pass the RAM read and merge steps,
// with a second merge step when the byte spans two pages. A clear-all
// sweeps the framebuffer one byte per cycle, then returns its word.
// After reset the same sweep runs once; in_ready stays low until it ends.
// The result sits in an output register, so the block takes the next
// request while a word waits; if the receiver stalls with a word still
// held, the next result waits in the block and in_ready stays low.
`default_nettype none
module mono_page_sprite_blitter_core
  import mpsb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_word,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_word
);

  localparam int PAGES       = SCREEN_HEIGHT / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam logic signed [17:0] XLIM = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] YLIM = 18'(SCREEN_HEIGHT);
  localparam logic signed [17:0] PLIM = 18'(PAGES);

  state_t state_r, state_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic sweep_resp_r, sweep_resp_nxt;

  logic signed [15:0] left_r, left_nxt, top_r, top_nxt;
  logic [7:0] width_r, width_nxt, colc_r, colc_nxt;
  logic [5:0] rows_r, rows_nxt, rowc_r, rowc_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic open_r, open_nxt, shown_r, shown_nxt;

  logic [AW-1:0] addr0_r, addr0_nxt, addr1_r, addr1_nxt;
  logic [7:0] bits0_r, bits0_nxt, bits1_r, bits1_nxt;
  logic wr0_r, wr0_nxt, wr1_r, wr1_nxt, is_read_r, is_read_nxt;
  rsp_t rsp_r, rsp_nxt;

  logic out_valid_r, out_valid_nxt;
  rsp_t out_word_r, out_word_nxt;

  logic accept;
  logic signed [17:0] py, cx, pg0, pg1, sum_x, sum_y;
  logic [2:0] off;
  logic col_ok, pg0_ok, pg1_ok, rd_ok;
  logic [15:0] shifted;
  logic [8:0] col_inc, h_ext;
  logic [5:0] row_inc;

  logic ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [7:0] ram_wr_data, ram_rd_data, merge_bits;

  function automatic logic [7:0] merge(input logic [7:0] old, input logic [7:0] bits,
                                       input logic [1:0] mode);
    logic [7:0] res;
    case (mode)
      MODE_SET:   res = old | bits;
      MODE_CLEAR: res = old & ~bits;
      default:    res = old ^ bits;
    endcase
    return res;
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    py      = $signed({{2{top_r[15]}}, top_r}) + $signed({9'b0, rowc_r, 3'b0});
    cx      = $signed({{2{left_r[15]}}, left_r}) + $signed({10'b0, colc_r});
    off     = py[2:0];
    pg0     = py >>> 3;
    pg1     = pg0 + 18'sd1;
    col_ok  = !cx[17] && (cx < XLIM);
    pg0_ok  = !pg0[17] && (pg0 < PLIM) && col_ok;
    pg1_ok  = !pg1[17] && (pg1 < PLIM) && col_ok && (off != 3'd0);
    shifted = {8'b0, in_word.data_byte} << off;
    sum_x   = $signed({{2{in_word.pos_x[15]}}, in_word.pos_x}) +
              $signed({10'b0, in_word.sprite_w});
    sum_y   = $signed({{2{in_word.pos_y[15]}}, in_word.pos_y}) +
              $signed({10'b0, in_word.sprite_h});
    rd_ok   = (32'(in_word.read_page) < PAGES) && (32'(in_word.read_column) < SCREEN_WIDTH);
    col_inc = {1'b0, colc_r} + 9'd1;
    row_inc = rowc_r + 6'd1;
    h_ext   = {1'b0, in_word.sprite_h} + 9'd7;
  end

  always_comb begin
    state_nxt      = state_r;
    sweep_nxt      = sweep_r;
    sweep_resp_nxt = sweep_resp_r;
    left_nxt       = left_r;
    top_nxt        = top_r;
    width_nxt      = width_r;
    rows_nxt       = rows_r;
    mode_nxt       = mode_r;
    colc_nxt       = colc_r;
    rowc_nxt       = rowc_r;
    open_nxt       = open_r;
    shown_nxt      = shown_r;
    addr0_nxt      = addr0_r;
    addr1_nxt      = addr1_r;
    bits0_nxt      = bits0_r;
    bits1_nxt      = bits1_r;
    wr0_nxt        = wr0_r;
    wr1_nxt        = wr1_r;
    is_read_nxt    = is_read_r;
    rsp_nxt        = rsp_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_word_nxt   = out_word_r;

    case (state_r)
      S_SWEEP: begin
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == AW'(STORE_BYTES - 1)) begin
          sweep_nxt = '0;
          state_nxt = sweep_resp_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          rsp_nxt     = '0;
          is_read_nxt = 1'b0;
          wr0_nxt     = 1'b0;
          wr1_nxt     = 1'b0;
          state_nxt   = S_RESP;
          case (in_word.req_type)
            REQ_HEADER: begin
              left_nxt  = in_word.pos_x;
              top_nxt   = in_word.pos_y;
              width_nxt = in_word.sprite_w;
              rows_nxt  = h_ext[8:3];
              mode_nxt  = in_word.draw_mode;
              colc_nxt  = '0;
              rowc_nxt  = '0;
              open_nxt  = (in_word.sprite_w != 8'd0) && (in_word.sprite_h != 8'd0);
              shown_nxt = !(sum_x[17] ||
                            ($signed({{2{in_word.pos_x[15]}}, in_word.pos_x}) >= XLIM) ||
                            sum_y[17] ||
                            ($signed({{2{in_word.pos_y[15]}}, in_word.pos_y}) >= YLIM));
            end
            REQ_DATA: begin
              if (!open_r) begin
                rsp_nxt.stray_byte = 1'b1;
              end else begin
                colc_nxt = col_inc[7:0];
                if (col_inc >= {1'b0, width_r}) begin
                  colc_nxt = '0;
                  rowc_nxt = row_inc;
                  if (row_inc >= rows_r) begin
                    rowc_nxt            = '0;
                    open_nxt            = 1'b0;
                    rsp_nxt.sprite_done = 1'b1;
                  end
                end
                wr0_nxt   = shown_r && pg0_ok;
                wr1_nxt   = shown_r && pg1_ok;
                bits0_nxt = shifted[7:0];
                bits1_nxt = shifted[15:8];
                addr0_nxt = pg0_ok ? AW'(32'(pg0[8:0]) * SCREEN_WIDTH + 32'(cx[8:0])) : '0;
                addr1_nxt = pg1_ok ? AW'(32'(pg1[8:0]) * SCREEN_WIDTH + 32'(cx[8:0])) : '0;
                if (shown_r && (pg0_ok || pg1_ok)) begin
                  state_nxt = S_RD0;
                end
              end
            end
            REQ_READ: begin
              if (rd_ok) begin
                is_read_nxt = 1'b1;
                addr0_nxt   = AW'(32'(in_word.read_page) * SCREEN_WIDTH +
                                  32'(in_word.read_column));
                state_nxt   = S_RD0;
              end
            end
            default: begin
              sweep_nxt      = '0;
              sweep_resp_nxt = 1'b1;
              state_nxt      = S_SWEEP;
            end
          endcase
        end
      end
      S_RD0: begin
        state_nxt = S_MRG0;
      end
      S_MRG0: begin
        if (is_read_r) begin
          rsp_nxt.read_data = ram_rd_data;
          state_nxt         = S_RESP;
        end else begin
          state_nxt = wr1_r ? S_MRG1 : S_RESP;
        end
      end
      S_MRG1: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = rsp_r;
          sweep_resp_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    merge_bits  = (state_r == S_MRG1) ? bits1_r : bits0_r;
    ram_rd_en   = (state_r == S_RD0) || (state_r == S_MRG0);
    ram_rd_addr = (state_r == S_MRG0) ? addr1_r : addr0_r;
    if (state_r == S_SWEEP) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = sweep_r;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = ((state_r == S_MRG0) && wr0_r && !is_read_r) ||
                    ((state_r == S_MRG1) && wr1_r);
      ram_wr_addr = (state_r == S_MRG1) ? addr1_r : addr0_r;
      ram_wr_data = merge(ram_rd_data, merge_bits, mode_r);
    end
  end

  mpsb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_frame_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      sweep_r      <= '0;
      sweep_resp_r <= 1'b0;
      left_r       <= '0;
      top_r        <= '0;
      width_r      <= '0;
      rows_r       <= '0;
      mode_r       <= '0;
      colc_r       <= '0;
      rowc_r       <= '0;
      open_r       <= 1'b0;
      shown_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_r      <= sweep_nxt;
      sweep_resp_r <= sweep_resp_nxt;
      left_r       <= left_nxt;
      top_r        <= top_nxt;
      width_r      <= width_nxt;
      rows_r       <= rows_nxt;
      mode_r       <= mode_nxt;
      colc_r       <= colc_nxt;
      rowc_r       <= rowc_nxt;
      open_r       <= open_nxt;
      shown_r      <= shown_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr0_r    <= addr0_nxt;
    addr1_r    <= addr1_nxt;
    bits0_r    <= bits0_nxt;
    bits1_r    <= bits1_nxt;
    wr0_r      <= wr0_nxt;
    wr1_r      <= wr1_nxt;
    is_read_r  <= is_read_nxt;
    rsp_r      <= rsp_nxt;
    out_word_r <= out_word_nxt;
  end

  // A new result word is only loaded from the response step.
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result word loaded outside the response step");

  a_reset_sweeps: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_SWEEP) && (sweep_r == '0))
    else $error("framebuffer sweep did not start after reset");

  a_done_not_stray: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_word_r.sprite_done && out_word_r.stray_byte))
    else $error("result word flags both sprite end and stray byte");

  a_close_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(open_r) |-> $past(accept))
    else $error("sprite closed without an accepted word");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) || (state_r == S_RESP) || (state_r == S_RD0)) |-> !ram_wr_en)
    else $error("framebuffer written outside a merge or sweep step");

endmodule
`default_nettype wire
